@@ hw/rtl/thc_pkg.sv @@
// shared constants and types for the tilt compensated heading pipeline
`timescale 1ns / 1ps
package thc_pkg;

    localparam int CORDIC_STAGES_DEF = 16;
    localparam int ATAN_N            = 24;

    localparam int CAL_W  = 18;
    localparam int TRIG_W = 17;
    localparam int XH_W   = 51;

    localparam logic [31:0] ATAN_TAB [0:ATAN_N-1] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
        32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
        32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
        32'd166886,    32'd83443,     32'd41722,     32'd20861,
        32'd10430,     32'd5215,      32'd2608,      32'd1304,
        32'd652,       32'd326,       32'd163,       32'd81
    };

    typedef enum logic [2:0] {
        REG_OFFSET_X = 3'd0,
        REG_OFFSET_Y = 3'd1,
        REG_OFFSET_Z = 3'd2,
        REG_GAIN_X   = 3'd3,
        REG_GAIN_Y   = 3'd4,
        REG_GAIN_Z   = 3'd5
    } t_reg_idx;

    typedef struct packed {
        logic signed [CAL_W-1:0] mx;
        logic signed [CAL_W-1:0] my;
        logic signed [CAL_W-1:0] mz;
    } t_cal;

endpackage

@@ hw/rtl/thc_sincos.sv @@
// pipelined sine and cosine of an angle in 1/100 degree, q15 results
`timescale 1ns / 1ps
module thc_sincos #(
    parameter int STAGES = thc_pkg::CORDIC_STAGES_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_en,
    input  logic signed [15:0]                  i_angle,
    output logic signed [thc_pkg::TRIG_W-1:0]   o_sin,
    output logic signed [thc_pkg::TRIG_W-1:0]   o_cos
);
    import thc_pkg::*;

    localparam int XW = 34;
    localparam int ZW = 34;

    logic signed [16:0] s_a;
    logic signed [16:0] s_am;
    logic               s_flip;
    logic               s_neg;

    logic [13:0]  r1_mag;
    logic         r1_neg, r1_flip;
    logic [22:0]  r2_v;
    logic [30:0]  r2_bq;
    logic         r2_neg, r2_flip;
    logic [12:0]  r3_qe;
    logic [22:0]  r3_v;
    logic [30:0]  r3_bq;
    logic         r3_neg, r3_flip;
    logic [23:0]  r4_r;
    logic [12:0]  r4_qe;
    logic [22:0]  r4_v;
    logic [30:0]  r4_bq;
    logic         r4_neg, r4_flip;
    logic signed [ZW-1:0] r5_z;
    logic         r5_flip;

    logic [44:0]  s_prod;
    logic [22:0]  s_rem;
    logic [30:0]  s_bmag;

    logic signed [XW-1:0] r_x [0:STAGES-1];
    logic signed [XW-1:0] r_y [0:STAGES-1];
    logic signed [ZW-1:0] r_z [0:STAGES-1];
    logic                 r_f [0:STAGES-1];

    logic signed [XW-1:0] s_xr, s_yr;
    logic signed [XW-1:0] s_cq, s_sq;
    logic signed [TRIG_W-1:0] r_sin, r_cos;

    // wrap to half turn, fold into quarter turn
    always_comb begin
        s_a = {i_angle[15], i_angle};
        if (s_a >= 17'sd18000) begin
            s_a = s_a - 17'sd36000;
        end else if (s_a < -17'sd18000) begin
            s_a = s_a + 17'sd36000;
        end
        s_flip = 1'b0;
        if (s_a > 17'sd9000) begin
            s_a    = s_a - 17'sd18000;
            s_flip = 1'b1;
        end else if (s_a < -17'sd9000) begin
            s_a    = s_a + 17'sd18000;
            s_flip = 1'b1;
        end
        s_neg = s_a < 17'sd0;
        s_am  = s_neg ? -s_a : s_a;
    end

    // binary angle = round(mag * 2^32 / 36000) via reciprocal
    assign s_prod = {22'b0, r2_v} * 45'd3817748;
    assign s_rem  = r4_v - r4_r[22:0];
    assign s_bmag = r4_bq + {18'b0, r4_qe} + {30'b0, (s_rem >= 23'd1125)};

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_mag  <= s_am[13:0];
            r1_neg  <= s_neg;
            r1_flip <= s_flip;
            r2_v    <= {9'b0, r1_mag} * 23'd728 + 23'd562;
            r2_bq   <= {17'b0, r1_mag} * 31'd119304;
            r2_neg  <= r1_neg;
            r2_flip <= r1_flip;
            r3_qe   <= s_prod[44:32];
            r3_v    <= r2_v;
            r3_bq   <= r2_bq;
            r3_neg  <= r2_neg;
            r3_flip <= r2_flip;
            r4_r    <= {11'b0, r3_qe} * 24'd1125;
            r4_qe   <= r3_qe;
            r4_v    <= r3_v;
            r4_bq   <= r3_bq;
            r4_neg  <= r3_neg;
            r4_flip <= r3_flip;
            r5_z    <= r4_neg ? -$signed({3'b0, s_bmag}) : $signed({3'b0, s_bmag});
            r5_flip <= r4_flip;
        end
    end

    for (genvar k = 0; k < STAGES; k++) begin : g_stage
        logic signed [XW-1:0] s_xi, s_yi;
        logic signed [ZW-1:0] s_zi;
        logic                 s_fi;
        logic signed [ZW-1:0] s_at;
        if (k == 0) begin : g_first
            assign s_xi = XW'(652032874);
            assign s_yi = '0;
            assign s_zi = r5_z;
            assign s_fi = r5_flip;
        end else begin : g_next
            assign s_xi = r_x[k-1];
            assign s_yi = r_y[k-1];
            assign s_zi = r_z[k-1];
            assign s_fi = r_f[k-1];
        end
        assign s_at = $signed({{(ZW-32){1'b0}}, ATAN_TAB[k]});
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (s_zi >= 0) begin
                    r_x[k] <= s_xi - (s_yi >>> k);
                    r_y[k] <= s_yi + (s_xi >>> k);
                    r_z[k] <= s_zi - s_at;
                end else begin
                    r_x[k] <= s_xi + (s_yi >>> k);
                    r_y[k] <= s_yi - (s_xi >>> k);
                    r_z[k] <= s_zi + s_at;
                end
                r_f[k] <= s_fi;
            end
        end
    end

    assign s_xr = r_x[STAGES-1] + XW'(16384);
    assign s_yr = r_y[STAGES-1] + XW'(16384);
    assign s_cq = s_xr >>> 15;
    assign s_sq = s_yr >>> 15;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_cos <= r_f[STAGES-1] ? -s_cq[TRIG_W-1:0] : s_cq[TRIG_W-1:0];
            r_sin <= r_f[STAGES-1] ? -s_sq[TRIG_W-1:0] : s_sq[TRIG_W-1:0];
        end
    end

    assign o_sin = r_sin;
    assign o_cos = r_cos;

endmodule

@@ hw/rtl/thc_atan2.sv @@
// pipelined vectoring cordic giving the heading in 1/100 degree
`timescale 1ns / 1ps
module thc_atan2 #(
    parameter int STAGES = thc_pkg::CORDIC_STAGES_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_en,
    input  logic signed [thc_pkg::XH_W-1:0]   i_x,
    input  logic signed [thc_pkg::XH_W-1:0]   i_y,
    output logic [15:0]                       o_heading
);
    import thc_pkg::*;

    localparam int VW = 54;
    localparam int ZW = 34;

    logic signed [VW-1:0] s_x, s_y;
    logic signed [VW-1:0] r0_x, r0_y;
    logic signed [ZW-1:0] r0_z;
    logic                 r0_zero;

    logic signed [VW-1:0] r_x [0:STAGES-1];
    logic signed [VW-1:0] r_y [0:STAGES-1];
    logic signed [ZW-1:0] r_z [0:STAGES-1];
    logic                 r_zr [0:STAGES-1];

    logic signed [50:0] r_prod;
    logic               r_pzero;
    logic signed [50:0] s_t;
    logic signed [18:0] s_h;
    logic [15:0]        r_heading;

    assign s_x = VW'(i_x);
    assign s_y = VW'(i_y);

    // pre-rotate the left half plane by a quarter turn
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r0_zero <= (i_x == '0) && (i_y == '0);
            if (s_x < 0) begin
                if (s_y >= 0) begin
                    r0_x <= s_y;
                    r0_y <= -s_x;
                    r0_z <= ZW'(1073741824);
                end else begin
                    r0_x <= -s_y;
                    r0_y <= s_x;
                    r0_z <= -ZW'(1073741824);
                end
            end else begin
                r0_x <= s_x;
                r0_y <= s_y;
                r0_z <= '0;
            end
        end
    end

    for (genvar k = 0; k < STAGES; k++) begin : g_stage
        logic signed [VW-1:0] s_xi, s_yi;
        logic signed [ZW-1:0] s_zi;
        logic                 s_ni;
        logic signed [ZW-1:0] s_at;
        if (k == 0) begin : g_first
            assign s_xi = r0_x;
            assign s_yi = r0_y;
            assign s_zi = r0_z;
            assign s_ni = r0_zero;
        end else begin : g_next
            assign s_xi = r_x[k-1];
            assign s_yi = r_y[k-1];
            assign s_zi = r_z[k-1];
            assign s_ni = r_zr[k-1];
        end
        assign s_at = $signed({{(ZW-32){1'b0}}, ATAN_TAB[k]});
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (s_yi >= 0) begin
                    r_x[k] <= s_xi + (s_yi >>> k);
                    r_y[k] <= s_yi - (s_xi >>> k);
                    r_z[k] <= s_zi + s_at;
                end else begin
                    r_x[k] <= s_xi - (s_yi >>> k);
                    r_y[k] <= s_yi + (s_xi >>> k);
                    r_z[k] <= s_zi - s_at;
                end
                r_zr[k] <= s_ni;
            end
        end
    end

    // binary angle to 1/100 degree and wrap
    assign s_t = r_prod + 51'sd2147483648;
    always_comb begin
        s_h = s_t[50:32];
        if (s_h < 0) begin
            s_h = s_h + 19'sd36000;
        end else if (s_h >= 19'sd36000) begin
            s_h = s_h - 19'sd36000;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod    <= 51'(r_z[STAGES-1]) * 51'sd36000;
            r_pzero   <= r_zr[STAGES-1];
            r_heading <= r_pzero ? 16'd0 : s_h[15:0];
        end
    end

    assign o_heading = r_heading;

endmodule

@@ hw/rtl/tilt_compensated_heading.sv @@
// top level: calibration, projection, output skid and register port
`timescale 1ns / 1ps
// Tilt compensated compass heading.
// Input stream: one beat holds a magnetometer sample and the roll and pitch
// angles; each beat yields exactly one output beat with the heading in
// 1/100 degree, 0 to 35999, in the order the inputs were taken.
// Registers (apb, byte address 4*i): offset x/y/z, gain x/y/z (q4.12).
// Write them only while no beat is in flight.
// Throughput: one beat per cycle while the receiver does not stall, set by the fully unrolled cordic pipelines.
// From input beat to output valid, a beat passes the sine/cosine pipe, the
// projection, the atan2 pipe and the output register.
// Reset clears all valid bits and sets offsets to 0 and gains to 1.0.
// When the receiver stalls, the output register holds its beat and one more
// beat lands in a skid register; then s_axis_tready drops and the whole
// pipeline freezes, losing nothing.
module tilt_compensated_heading #(
    parameter int CORDIC_STAGES = thc_pkg::CORDIC_STAGES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // field_x, field_y, field_z, roll_angle, pitch_angle
    input  logic [79:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // heading
    output logic [15:0] m_axis_tdata,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import thc_pkg::*;

    localparam int LAT = 2 * CORDIC_STAGES + 13;
    localparam int DLY = CORDIC_STAGES + 4;

    logic signed [15:0] r_off_x, r_off_y, r_off_z;
    logic [15:0]        r_gain_x, r_gain_y, r_gain_z;
    t_reg_idx           s_idx;
    logic               s_wr;

    logic               w_en;
    logic [LAT-1:0]     r_vld;

    logic signed [15:0] s_fx, s_fy, s_fz, s_roll, s_pitch;
    logic signed [16:0] r_dx, r_dy, r_dz;
    logic [15:0]        r_gx, r_gy, r_gz;
    logic signed [33:0] r_px, r_py, r_pz;
    t_cal               s_cal;
    t_cal               r_mdl [0:DLY-1];
    t_cal               s_m;

    logic signed [TRIG_W-1:0] s_sr, s_cr, s_sp, s_cp;
    logic signed [TRIG_W-1:0] r_sp1, r_sp2;
    logic signed [34:0] r_s1, r_a, r_b, r_c, r_d;
    logic signed [34:0] r_s1b, r_s1c;
    logic signed [35:0] r_s2, r_yq;
    logic signed [52:0] r_m;
    logic signed [XH_W-1:0] r_yn, r_xh, r_yv;
    logic [15:0]        s_head;

    logic               r_out_v, r_skid_v;
    logic [15:0]        r_out, r_skid;

    // register port
    assign pready = 1'b1;
    assign s_idx  = t_reg_idx'(paddr[4:2]);
    assign s_wr   = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_off_x  <= '0;
            r_off_y  <= '0;
            r_off_z  <= '0;
            r_gain_x <= 16'd4096;
            r_gain_y <= 16'd4096;
            r_gain_z <= 16'd4096;
        end else if (s_wr && paddr[1:0] == 2'b00) begin
            case (s_idx)
                REG_OFFSET_X: r_off_x  <= pwdata[15:0];
                REG_OFFSET_Y: r_off_y  <= pwdata[15:0];
                REG_OFFSET_Z: r_off_z  <= pwdata[15:0];
                REG_GAIN_X:   r_gain_x <= pwdata[15:0];
                REG_GAIN_Y:   r_gain_y <= pwdata[15:0];
                REG_GAIN_Z:   r_gain_z <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr[1:0] == 2'b00) begin
            case (s_idx)
                REG_OFFSET_X: prdata = {16'b0, r_off_x};
                REG_OFFSET_Y: prdata = {16'b0, r_off_y};
                REG_OFFSET_Z: prdata = {16'b0, r_off_z};
                REG_GAIN_X:   prdata = {16'b0, r_gain_x};
                REG_GAIN_Y:   prdata = {16'b0, r_gain_y};
                REG_GAIN_Z:   prdata = {16'b0, r_gain_z};
                default:      prdata = '0;
            endcase
        end
    end

    // pipeline advances unless the skid register is occupied
    assign w_en          = !r_skid_v;
    assign s_axis_tready = w_en;

    assign s_fx    = s_axis_tdata[15:0];
    assign s_fy    = s_axis_tdata[31:16];
    assign s_fz    = s_axis_tdata[47:32];
    assign s_roll  = s_axis_tdata[63:48];
    assign s_pitch = s_axis_tdata[79:64];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[LAT-2:0], s_axis_tvalid};
        end
    end

    // calibration: (raw - offset) * gain, rounded, saturated to 18 bits
    function automatic logic signed [CAL_W-1:0] sat_cal(input logic signed [33:0] p);
        logic signed [33:0] t;
        t = (p + 34'sd2048) >>> 12;
        if (t > 34'sd131071) begin
            return 18'sd131071;
        end else if (t < -34'sd131072) begin
            return -18'sd131072;
        end
        return t[CAL_W-1:0];
    endfunction

    assign s_cal.mx = sat_cal(r_px);
    assign s_cal.my = sat_cal(r_py);
    assign s_cal.mz = sat_cal(r_pz);
    assign s_m      = r_mdl[DLY-1];

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_dx <= {s_fx[15], s_fx} - {r_off_x[15], r_off_x};
            r_dy <= {s_fy[15], s_fy} - {r_off_y[15], r_off_y};
            r_dz <= {s_fz[15], s_fz} - {r_off_z[15], r_off_z};
            r_gx <= r_gain_x;
            r_gy <= r_gain_y;
            r_gz <= r_gain_z;
            r_px <= r_dx * $signed({1'b0, r_gx});
            r_py <= r_dy * $signed({1'b0, r_gy});
            r_pz <= r_dz * $signed({1'b0, r_gz});
            r_mdl[0] <= s_cal;
            for (int k = 1; k < DLY; k++) begin
                r_mdl[k] <= r_mdl[k-1];
            end
        end
    end

    thc_sincos #(.STAGES(CORDIC_STAGES)) u_roll (
        .i_clk   (i_clk),
        .i_en    (w_en),
        .i_angle (s_roll),
        .o_sin   (s_sr),
        .o_cos   (s_cr)
    );

    thc_sincos #(.STAGES(CORDIC_STAGES)) u_pitch (
        .i_clk   (i_clk),
        .i_en    (w_en),
        .i_angle (s_pitch),
        .o_sin   (s_sp),
        .o_cos   (s_cp)
    );

    // projection into the horizontal plane
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s1  <= s_m.mx * s_cp;
            r_a   <= s_m.my * s_sr;
            r_b   <= s_m.mz * s_cr;
            r_c   <= s_m.my * s_cr;
            r_d   <= s_m.mz * s_sr;
            r_sp1 <= s_sp;
            r_s2  <= 36'(r_a) + 36'(r_b);
            r_yq  <= 36'(r_c) - 36'(r_d);
            r_s1b <= r_s1;
            r_sp2 <= r_sp1;
            r_m   <= r_s2 * r_sp2;
            r_s1c <= r_s1b;
            r_yn  <= -$signed({r_yq, 15'b0});
            r_xh  <= $signed({r_s1c[34], r_s1c, 15'b0}) + r_m[XH_W-1:0];
            r_yv  <= r_yn;
        end
    end

    thc_atan2 #(.STAGES(CORDIC_STAGES)) u_atan2 (
        .i_clk     (i_clk),
        .i_en      (w_en),
        .i_x       (r_xh),
        .i_y       (r_yv),
        .o_heading (s_head)
    );

    // output register with one-beat skid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else if (w_en) begin
            if (!r_out_v || m_axis_tready) begin
                r_out_v <= r_vld[LAT-1];
            end else if (r_vld[LAT-1]) begin
                r_skid_v <= 1'b1;
            end
        end else if (m_axis_tready) begin
            r_skid_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            if (!r_out_v || m_axis_tready) begin
                r_out <= s_head;
            end else begin
                r_skid <= s_head;
            end
        end else if (m_axis_tready) begin
            r_out <= r_skid;
        end
    end

    assign m_axis_tvalid = r_out_v;
    assign m_axis_tdata  = r_out;

endmodule

@@ dv/heading_checker.sv @@
// checker: watches the streams and register port, predicts and compares headings
`timescale 1ns / 1ps
module heading_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [79:0] s_axis_tdata,
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [15:0] m_axis_tdata,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic        pready,
    output int          o_errors,
    output int          o_pending
);
    import thc_pkg::*;

    localparam int STAGES = 16;
    localparam longint ONE_OVER_K = 652032874;
    localparam longint ARCTAN [0:23] = '{
        536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
        10679838, 5340245, 2670163, 1335087, 667544, 333772,
        166886, 83443, 41722, 20861, 10430, 5215,
        2608, 1304, 652, 326, 163, 81
    };

    longint off_x, off_y, off_z, gn_x, gn_y, gn_z;
    logic [15:0] heading_q[$];
    int errors;

    assign o_errors  = errors;
    assign o_pending = heading_q.size();

    function automatic longint calib(longint raw, longint off, longint gain);
        longint m;
        m = ((raw - off) * gain + 2048) >>> 12;
        if (m > 131071) m = 131071;
        if (m < -131072) m = -131072;
        return m;
    endfunction

    function automatic void sin_cos(input longint ang, output longint s, output longint c);
        logic flip;
        longint unsigned mag;
        longint b, x, y, z, nx;
        flip = 1'b0;
        if (ang >= 18000) ang -= 36000;
        if (ang < -18000) ang += 36000;
        if (ang > 9000) begin
            ang -= 18000;
            flip = 1'b1;
        end else if (ang < -9000) begin
            ang += 18000;
            flip = 1'b1;
        end
        mag = (ang < 0) ? -ang : ang;
        b = ((mag << 32) + 18000) / 36000;
        if (ang < 0) b = -b;
        x = ONE_OVER_K;
        y = 0;
        z = b;
        for (int i = 0; i < STAGES; i++) begin
            if (z >= 0) begin
                nx = x - (y >>> i); y = y + (x >>> i); z -= ARCTAN[i];
            end else begin
                nx = x + (y >>> i); y = y - (x >>> i); z += ARCTAN[i];
            end
            x = nx;
        end
        x = (x + 16384) >>> 15;
        y = (y + 16384) >>> 15;
        if (flip) begin
            x = -x;
            y = -y;
        end
        s = y;
        c = x;
    endfunction

    function automatic longint vector_heading(longint vx, longint vy);
        longint z, t, nx, h;
        z = 0;
        if (vx == 0 && vy == 0) return 0;
        if (vx < 0) begin
            if (vy >= 0) begin
                t = vx; vx = vy; vy = -t; z = 1073741824;
            end else begin
                t = vx; vx = -vy; vy = t; z = -1073741824;
            end
        end
        for (int i = 0; i < STAGES; i++) begin
            if (vy >= 0) begin
                nx = vx + (vy >>> i); vy = vy - (vx >>> i); z += ARCTAN[i];
            end else begin
                nx = vx - (vy >>> i); vy = vy + (vx >>> i); z -= ARCTAN[i];
            end
            vx = nx;
        end
        h = (z * 36000 + 64'sd2147483648) >>> 32;
        if (h < 0) h += 36000;
        if (h >= 36000) h -= 36000;
        return h;
    endfunction

    function automatic logic [15:0] tilt_heading(logic [79:0] d);
        longint mx, my, mz, sr, cr, sp, cp, xh, yh;
        mx = calib(longint'($signed(d[15:0])), off_x, gn_x);
        my = calib(longint'($signed(d[31:16])), off_y, gn_y);
        mz = calib(longint'($signed(d[47:32])), off_z, gn_z);
        sin_cos(longint'($signed(d[63:48])), sr, cr);
        sin_cos(longint'($signed(d[79:64])), sp, cp);
        xh = mx * cp * 32768 + my * sr * sp + mz * cr * sp;
        yh = (my * cr - mz * sr) * 32768;
        return 16'(vector_heading(xh, -yh));
    endfunction

    always @(posedge i_clk) begin
        logic [15:0] want;
        if (!i_rst_n) begin
            off_x <= 0; off_y <= 0; off_z <= 0;
            gn_x <= 4096; gn_y <= 4096; gn_z <= 4096;
            errors <= 0;
            heading_q.delete();
        end else begin
            if (psel && penable && pwrite && pready) begin
                case (paddr[4:2])
                    REG_OFFSET_X: off_x <= longint'($signed(pwdata[15:0]));
                    REG_OFFSET_Y: off_y <= longint'($signed(pwdata[15:0]));
                    REG_OFFSET_Z: off_z <= longint'($signed(pwdata[15:0]));
                    REG_GAIN_X:   gn_x <= longint'(pwdata[15:0]);
                    REG_GAIN_Y:   gn_y <= longint'(pwdata[15:0]);
                    REG_GAIN_Z:   gn_z <= longint'(pwdata[15:0]);
                    default: ;
                endcase
            end
            if (s_axis_tvalid && s_axis_tready)
                heading_q.push_back(tilt_heading(s_axis_tdata));
            if (m_axis_tvalid && m_axis_tready) begin
                if (heading_q.size() == 0) begin
                    $display("%0t unexpected beat: expected none actual %0d",
                             $time, m_axis_tdata);
                    errors <= errors + 1;
                end else begin
                    want = heading_q.pop_front();
                    if (m_axis_tdata !== want) begin
                        $display("%0t heading mismatch: expected %0d actual %0d",
                                 $time, want, m_axis_tdata);
                        errors <= errors + 1;
                    end
                end
            end
        end
    end
endmodule

@@ dv/tb.sv @@
// testbench top: clock, reset, stimulus, stalls and verdict
`timescale 1ns / 1ps
module tb;
    import thc_pkg::*;

    localparam logic [2:0] REG_SPARE = 3'd6;
    localparam int DRAIN = 2 * 16 + 20;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [79:0] s_axis_tdata = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [4:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    int          errors, pending;
    logic        steady = 1'b0;

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    tilt_compensated_heading dut (.*);

    heading_checker chk (
        .i_clk, .i_rst_n, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
        .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .psel, .penable,
        .pwrite, .paddr, .pwdata, .pready, .o_errors(errors), .o_pending(pending)
    );

    task automatic reg_write(logic [2:0] idx, logic [15:0] val);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
        paddr <= {idx, 2'b00}; pwdata <= {16'(0), val};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    endtask

    task automatic set_calibration(logic [15:0] ox, oy, oz, gx, gy, gz);
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN) @(posedge i_clk);
        reg_write(REG_OFFSET_X, ox);
        reg_write(REG_OFFSET_Y, oy);
        reg_write(REG_OFFSET_Z, oz);
        reg_write(REG_GAIN_X, gx);
        reg_write(REG_GAIN_Y, gy);
        reg_write(REG_GAIN_Z, gz);
    endtask

    task automatic send_sample(logic [15:0] fx, fy, fz, roll, pitch);
        int gap;
        gap = steady ? 0 : $urandom_range(0, 14);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {pitch, roll, fz, fy, fx};
        @(negedge i_clk);
        while (!s_axis_tready) @(negedge i_clk);
        @(posedge i_clk);
    endtask

    function automatic logic [15:0] rand_angle();
        if ($urandom_range(0, 9) == 0) return 16'($urandom);
        return 16'($signed($urandom_range(0, 36000)) - 18000);
    endfunction

    task automatic random_samples(int n);
        for (int k = 0; k < n; k++) begin
            if (k % 40 == 0) steady = ($urandom_range(0, 3) == 0);
            send_sample(16'($urandom), 16'($urandom), 16'($urandom),
                        rand_angle(), rand_angle());
        end
        s_axis_tvalid <= 1'b0;
    endtask

    initial begin
        int stall;
        forever begin
            stall = steady ? 0 : $urandom_range(0, 14);
            if (stall > 0) begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            @(negedge i_clk);
            while (!m_axis_tvalid) @(negedge i_clk);
            @(posedge i_clk);
        end
    end

    initial begin
        #5ms;
        $display("RESULT: ERROR");
        $finish;
    end

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        // zero vector, field extremes and angle edge cases at reset calibration
        send_sample(16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
        send_sample(16'h8000, 16'h8000, 16'h8000, 16'd0, 16'd0);
        send_sample(16'h7fff, 16'h7fff, 16'h7fff, 16'd0, 16'd0);
        send_sample(16'h7fff, 16'h8000, 16'd0, 16'd9000, 16'd9000);
        send_sample(16'h8000, 16'h7fff, 16'd0, -16'sd9000, -16'sd9000);
        send_sample(16'd100, 16'd0, 16'd50, 16'd18000, -16'sd18000);
        send_sample(16'd100, 16'd200, 16'd50, 16'd9001, -16'sd9001);
        send_sample(-16'sd300, 16'd20, 16'd50, 16'h7fff, 16'h8000);
        send_sample(16'd0, 16'd500, 16'd0, 16'h8000, 16'h7fff);
        send_sample(16'd0, -16'sd500, 16'd0, 16'd17999, -16'sd17999);
        send_sample(-16'sd500, 16'd0, 16'd0, 16'd4500, 16'd27000);
        send_sample(-16'sd500, -16'sd1, 16'd0, -16'sd4500, 16'd0);
        s_axis_tvalid <= 1'b0;
        // gains at zero, out-of-range register index
        set_calibration(16'h7fff, 16'h8000, 16'd0, 16'd0, 16'd0, 16'd0);
        reg_write(REG_SPARE, 16'hffff);
        send_sample(16'd1, 16'd2, 16'd3, 16'd0, 16'd0);
        send_sample(16'h8000, 16'h7fff, 16'h8000, 16'd1000, -16'sd2000);
        random_samples(20);
        set_calibration(16'h8000, 16'h7fff, 16'h8000, 16'hffff, 16'hffff, 16'hffff);
        send_sample(16'h7fff, 16'h8000, 16'h7fff, 16'd0, 16'd0);
        random_samples(100);
        set_calibration(16'h7fff, 16'h7fff, 16'h7fff, 16'd4096, 16'hffff, 16'd1);
        random_samples(100);
        set_calibration(16'($urandom), 16'($urandom), 16'($urandom),
                        16'($urandom), 16'($urandom), 16'($urandom));
        random_samples(100);
        set_calibration(16'd0, 16'd0, 16'd0, 16'd4096, 16'd4096, 16'd4096);
        random_samples(120);
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN) @(posedge i_clk);
        if (errors == 0 && pending == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end
endmodule

@@ tilt_compensated_heading.f @@
hw/rtl/thc_pkg.sv
hw/rtl/thc_sincos.sv
hw/rtl/thc_atan2.sv
hw/rtl/tilt_compensated_heading.sv
dv/heading_checker.sv
dv/tb.sv
